// ----- rtl/core/ibusfr_pkg.sv -----
package ibusfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ChNumW     = 4;
  localparam int unsigned ChValW     = 12;
  localparam int unsigned PosW       = 5;
  localparam int unsigned SumW       = 16;
  localparam int unsigned FrameDepth = 32;

  localparam logic [ByteW-1:0] Hdr0 = 8'h20;
  localparam logic [ByteW-1:0] Hdr1 = 8'h40;

  localparam logic [SumW-1:0] SumBias = 16'h0060;
  localparam logic [SumW-1:0] SumMask = 16'hFFFF;

  localparam logic [PosW-1:0] PosHdr0   = 5'd0;
  localparam logic [PosW-1:0] PosHdr1   = 5'd1;
  localparam logic [PosW-1:0] PosCsumLo = 5'd30;
  localparam logic [PosW-1:0] PosCsumHi = 5'd31;

  // first payload byte of a frame
  localparam logic [PosW-1:0] PosPayload = 5'd2;

  localparam logic OpByte = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic KindFrame = 1'b0;
  localparam logic KindRead  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              take_byte;
    logic              take_read;
    logic              fetch;
    logic              emit;
    logic              emit_last;
    logic [ChNumW-1:0] ch;
  } ibusfr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_ok;
    logic out_free;
  } ibusfr_sts_t;

endpackage

// ----- rtl/core/ibusfr_in_if.sv -----
interface ibusfr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [ibusfr_pkg::ByteW-1:0]    rx_byte;
  logic [ibusfr_pkg::ChNumW-1:0]   channel_index;

  modport source (output valid, output operation, output rx_byte, output channel_index,
                  input ready);
  modport sink   (input valid, input operation, input rx_byte, input channel_index,
                  output ready);
endinterface

// ----- rtl/core/ibusfr_out_if.sv -----
interface ibusfr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [ibusfr_pkg::ChNumW-1:0]   channel_number;
  logic [ibusfr_pkg::ChValW-1:0]   channel_value;
  logic                            last;

  modport source (output valid, output kind, output channel_number, output channel_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input channel_number, input channel_value,
                  input last, output ready);
endinterface

// ----- rtl/core/ibusfr_ctrl.sv -----
module ibusfr_ctrl #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    operation_i,
  output logic                    in_ready_o,
  input  ibusfr_pkg::ibusfr_sts_t sts_i,
  output ibusfr_pkg::ibusfr_cmd_t cmd_o
);
  import ibusfr_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  localparam logic [ChNumW-1:0] LastCh = ChNumW'(CHANNELS - 1);

  logic [1:0]        state_q, state_d;
  logic [ChNumW-1:0] ch_q, ch_d;
  logic              accept;

  assign in_ready_o = (state_q == StIdle) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    ch_d            = ch_q;
    cmd_o           = '0;
    cmd_o.ch        = ch_q;
    cmd_o.emit_last = (ch_q == LastCh);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (operation_i == OpRead) begin
            cmd_o.take_read = 1'b1;
          end else begin
            cmd_o.take_byte = 1'b1;
            if (sts_i.frame_ok) begin
              state_d = StFetch;
              ch_d    = '0;
            end
          end
        end
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (ch_q == LastCh) begin
            state_d = StIdle;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = StFetch;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // the channel counter never runs past the configured count during an update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (ch_q <= LastCh))
    else $error("channel counter out of range");

  // emitting the last channel closes the update run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && (ch_q == LastCh)) |=> (state_q == StIdle))
    else $error("update run did not end after last channel");

  // no new word is taken while a channel update is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("input taken during channel update");

endmodule

// ----- rtl/core/ibusfr_dp.sv -----
module ibusfr_dp #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ibusfr_pkg::ibusfr_cmd_t           cmd_i,
  output ibusfr_pkg::ibusfr_sts_t           sts_o,
  input  logic [ibusfr_pkg::ByteW-1:0]      rx_byte_i,
  input  logic [ibusfr_pkg::ChNumW-1:0]     channel_index_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              kind_o,
  output logic [ibusfr_pkg::ChNumW-1:0]     channel_number_o,
  output logic [ibusfr_pkg::ChValW-1:0]     channel_value_o,
  output logic                              last_o
);
  import ibusfr_pkg::*;

  localparam int unsigned StoreAw = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // parser state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] csum_lo_q;

  // frame buffer and its read registers
  logic [ByteW-1:0] frame_mem [FrameDepth];
  logic [ByteW-1:0] lo_q, hi_q;
  logic [PosW-1:0]  lo_addr, hi_addr;

  // channel store
  logic [ChValW-1:0] store_q [CHANNELS];
  logic [ChValW-1:0] emit_val;
  logic [ChValW-1:0] read_val;

  // output register
  logic              out_valid_q;
  logic              kind_q;
  logic [ChNumW-1:0] num_q;
  logic [ChValW-1:0] val_q;
  logic              last_q;
  logic              out_load;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.frame_ok = (pos_q == PosCsumHi) &&
                          ({rx_byte_i, csum_lo_q} == ((sum_q + SumBias) ^ SumMask));

  // byte parser: hunt for the header, sum payload, hold checksum low byte
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (cmd_i.take_byte) begin
      priority if (pos_q == PosHdr0) begin
        pos_d = (rx_byte_i == Hdr0) ? PosHdr1 : PosHdr0;
      end else if (pos_q == PosHdr1) begin
        if (rx_byte_i == Hdr1) begin
          sum_d = '0;
          pos_d = PosPayload;
        end else begin
          pos_d = PosHdr0;
        end
      end else if (pos_q < PosCsumLo) begin
        sum_d = sum_q + SumW'(rx_byte_i);
        pos_d = pos_q + 1'b1;
      end else if (pos_q == PosCsumLo) begin
        pos_d = PosCsumHi;
      end else begin
        pos_d = PosHdr0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHdr0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && (pos_q == PosCsumLo)) begin
      csum_lo_q <= rx_byte_i;
    end
  end

  // channel i sits in bytes 2+2i (low) and 3+2i (high nibble)
  assign lo_addr = {cmd_i.ch, 1'b0} + PosPayload;
  assign hi_addr = {cmd_i.ch, 1'b1} + PosPayload;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      frame_mem[pos_q] <= rx_byte_i;
    end
    if (cmd_i.fetch) begin
      lo_q <= frame_mem[lo_addr];
      hi_q <= frame_mem[hi_addr];
    end
  end

  assign emit_val = {hi_q[ChValW-ByteW-1:0], lo_q};
  assign read_val = (channel_index_i < ChNumW'(CHANNELS)) ?
                    store_q[channel_index_i[StoreAw-1:0]] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.emit) begin
      store_q[cmd_i.ch[StoreAw-1:0]] <= emit_val;
    end
  end

  assign out_load = cmd_i.emit || cmd_i.take_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= KindFrame;
      num_q  <= cmd_i.ch;
      val_q  <= emit_val;
      last_q <= cmd_i.emit_last;
    end else if (cmd_i.take_read) begin
      kind_q <= KindRead;
      num_q  <= channel_index_i;
      val_q  <= read_val;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign channel_number_o = num_q;
  assign channel_value_o  = val_q;
  assign last_o           = last_q;

  // commands are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.take_byte, cmd_i.take_read, cmd_i.fetch, cmd_i.emit}))
    else $error("overlapping datapath commands");

  // a read reply is always a single final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_read |=> (out_valid_q && (kind_q == KindRead) && last_q))
    else $error("read reply malformed");

  // a word is only loaded when the output slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> sts_o.out_free)
    else $error("output word overwritten");

endmodule

// ----- rtl/core/ibus_frame_receiver_core.sv -----
// Timing: a read reply is valid on the cycle after the read word is accepted.
// Throughput: one input word per cycle while the output drains; a good frame end stops input
//   until every channel is stored: frame buffer read, then store write once output is free.
// Reset (rst_ni, asynchronous, active low): parser hunts for the header, sum and all stored
//   channels clear to zero, output empty; the frame buffer is not cleared.
module ibus_frame_receiver_core #(
  parameter int unsigned CHANNELS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ibusfr_in_if.sink    rx_i,
  ibusfr_out_if.source res_o
);
  import ibusfr_pkg::*;

  ibusfr_cmd_t cmd;
  ibusfr_sts_t sts;

  // Controller: hold the input while a channel update is running, and step
  // through the channels once a frame passes its checksum.
  ibusfr_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .operation_i (rx_i.operation),
    .in_ready_o  (rx_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: byte parser with running sum, frame buffer, channel store and
  // the output register that parts the two handshake sides.
  ibusfr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rx_byte_i        (rx_i.rx_byte),
    .channel_index_i  (rx_i.channel_index),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .kind_o           (res_o.kind),
    .channel_number_o (res_o.channel_number),
    .channel_value_o  (res_o.channel_value),
    .last_o           (res_o.last)
  );

endmodule

// ----- tb/tb_ibus_frame_receiver_core.sv -----
`timescale 1ns / 1ps

module tb_ibus_frame_receiver_core;
  import ibusfr_pkg::*;

  localparam int Chans      = 14;
  localparam int RandItems  = 275;
  localparam int CycleLimit = 400000;
  localparam int DirRows    = 20;

  // one word on the receive channel
  typedef struct packed {
    logic              op;
    logic [ByteW-1:0]  rx_byte;
    logic [ChNumW-1:0] ch_idx;
  } in_word_t;

  // one word on the result channel
  typedef struct packed {
    logic              kind;
    logic [ChNumW-1:0] ch_num;
    logic [ChValW-1:0] ch_val;
    logic              last;
  } chan_res_t;

  typedef enum logic {RowWord, RowFrame} row_kind_e;

  // A directed row is either a single word or a whole frame. A frame row builds its payload
  // as base + stride * n and may carry a corrupted checksum. A typed row brings its own
  // expected result; all others go through the frame predictor.
  typedef struct packed {
    row_kind_e        kind;
    in_word_t         word;
    logic [ByteW-1:0] base;
    logic [ByteW-1:0] stride;
    logic             bad;
    logic             typed;
    chan_res_t        res;
  } plan_row_t;

  localparam plan_row_t DirPlan [DirRows] = '{
    // reads straight after reset: every channel is zero, out of range too
    '{RowWord,  '{OpRead, 8'h00, 4'd0},  8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd0,  12'h000, 1'b1}},
    '{RowWord,  '{OpRead, 8'hFF, 4'd13}, 8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd13, 12'h000, 1'b1}},
    '{RowWord,  '{OpRead, 8'h00, 4'd15}, 8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd15, 12'h000, 1'b1}},
    // noise while hunting, then a first header byte followed by a wrong second one
    '{RowWord,  '{OpByte, 8'h00, 4'd0},  8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpByte, 8'hFF, 4'd15}, 8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpByte, 8'h20, 4'd0},  8'h00, 8'h00, 1'b0, 1'b0, '0},
    // the repeated 0x20 is dropped, not taken as a new header, so 0x40 lands in hunt
    '{RowWord,  '{OpByte, 8'h20, 4'd0},  8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpByte, 8'h40, 4'd0},  8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowFrame, '0,                      8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpRead, 8'h00, 4'd0},  8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd0,  12'h000, 1'b1}},
    // all-ones payload: the high nibble mask gives full scale on every channel
    '{RowFrame, '0,                      8'hFF, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpRead, 8'h00, 4'd0},  8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd0,  12'hFFF, 1'b1}},
    '{RowWord,  '{OpRead, 8'h00, 4'd13}, 8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd13, 12'hFFF, 1'b1}},
    '{RowWord,  '{OpRead, 8'h00, 4'd14}, 8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd14, 12'h000, 1'b1}},
    // checksum mismatch leaves the channels alone
    '{RowFrame, '0,                      8'h01, 8'h13, 1'b1, 1'b0, '0},
    '{RowWord,  '{OpRead, 8'h00, 4'd13}, 8'h00, 8'h00, 1'b0, 1'b1, '{KindRead, 4'd13, 12'hFFF, 1'b1}},
    '{RowFrame, '0,                      8'h10, 8'h25, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpRead, 8'h5A, 4'd7},  8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{RowFrame, '0,                      8'hA5, 8'h00, 1'b0, 1'b0, '0},
    '{RowWord,  '{OpRead, 8'hC3, 4'd12}, 8'h00, 8'h00, 1'b0, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  ibusfr_in_if  rx_if ();
  ibusfr_out_if res_if ();

  ibus_frame_receiver_core #(
    .CHANNELS(Chans)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // Predictor state: parser position, running sum, frame buffer and channel store
  logic [PosW-1:0]   pred_pos;
  logic [SumW-1:0]   pred_sum;
  logic [ByteW-1:0]  pred_buf [FrameDepth];
  logic [ChValW-1:0] pred_chan [Chans];

  chan_res_t        exp_chan_q[$];   // results still owed by the block, oldest first
  logic [ByteW-1:0] frame_tx [FrameDepth];
  int               err_cnt;
  int               cycle_cnt;
  int               words_counted;
  int               stall_left;

  always #5 clk_i = ~clk_i;

  // Run one accepted word through the parser and queue whatever results it owes.
  function automatic void predict_word(input in_word_t w);
    logic [SumW-1:0] want;
    logic [SumW-1:0] rx_csum;
    chan_res_t       r;
    if (w.op == OpRead) begin
      r.kind   = KindRead;
      r.ch_num = w.ch_idx;
      r.ch_val = (w.ch_idx < Chans) ? pred_chan[w.ch_idx] : '0;
      r.last   = 1'b1;
      exp_chan_q.push_back(r);
    end else if (pred_pos == PosHdr0) begin
      if (w.rx_byte == Hdr0) begin
        pred_buf[PosHdr0] = w.rx_byte;
        pred_pos          = PosHdr1;
      end
    end else if (pred_pos == PosHdr1) begin
      // a wrong second header byte is dropped, not retried as a first one
      if (w.rx_byte == Hdr1) begin
        pred_buf[PosHdr1] = w.rx_byte;
        pred_sum          = '0;
        pred_pos          = PosPayload;
      end else begin
        pred_pos = PosHdr0;
      end
    end else if (pred_pos < PosCsumLo) begin
      pred_buf[pred_pos] = w.rx_byte;
      pred_sum           = pred_sum + SumW'(w.rx_byte);
      pred_pos           = pred_pos + 1'b1;
    end else if (pred_pos == PosCsumLo) begin
      pred_buf[pred_pos] = w.rx_byte;
      pred_pos           = pred_pos + 1'b1;
    end else begin
      pred_buf[PosCsumHi] = w.rx_byte;
      pred_pos            = PosHdr0;
      want                = (pred_sum + SumBias) ^ SumMask;
      rx_csum             = {w.rx_byte, pred_buf[PosCsumLo]};
      if (want == rx_csum) begin
        for (int i = 0; i < Chans; i++) begin
          pred_chan[i] = {pred_buf[3 + 2 * i][3:0], pred_buf[2 + 2 * i]};
          r.kind       = KindFrame;
          r.ch_num     = ChNumW'(i);
          r.ch_val     = pred_chan[i];
          r.last       = (i == Chans - 1);
          exp_chan_q.push_back(r);
        end
      end
    end
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender gap; one stretch in four runs back to back with no gaps at all.
  function automatic int pick_gap();
    if (cycle_cnt[10:9] == 2'd0 || $urandom_range(0, 99) < 60) return 0;
    return pick_len();
  endfunction

  function automatic in_word_t byte_word(input logic [ByteW-1:0] b);
    byte_word = '{OpByte, b, ChNumW'($urandom)};
  endfunction

  function automatic in_word_t read_word(input logic [ChNumW-1:0] idx);
    read_word = '{OpRead, ByteW'($urandom), idx};
  endfunction

  // Build a frame in frame_tx: header, payload, then the checksum, corrupted on request.
  function automatic void fill_frame(input logic [ByteW-1:0] base, input logic [ByteW-1:0] stride,
                                     input bit scramble, input bit bad);
    logic [SumW-1:0] sum;
    logic [SumW-1:0] csum;
    sum         = '0;
    frame_tx[0] = Hdr0;
    frame_tx[1] = Hdr1;
    for (int i = PosPayload; i < PosCsumLo; i++) begin
      frame_tx[i] = scramble ? ByteW'($urandom) : ByteW'(base + stride * (i - PosPayload));
      sum         = sum + SumW'(frame_tx[i]);
    end
    csum = (sum + SumBias) ^ SumMask;
    if (bad) begin
      // spoil the low byte, the high byte, or random bits across both
      case ($urandom_range(0, 2))
        0:       csum = csum ^ {8'h00, ByteW'($urandom_range(1, 255))};
        1:       csum = csum ^ {ByteW'($urandom_range(1, 255)), 8'h00};
        default: csum = csum ^ SumW'($urandom_range(1, 65535));
      endcase
    end
    frame_tx[PosCsumLo] = csum[7:0];
    frame_tx[PosCsumHi] = csum[15:8];
  endfunction

  // Present one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input chan_res_t typed_res = '0);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid         <= 1'b1;
    rx_if.operation     <= w.op;
    rx_if.rx_byte       <= w.rx_byte;
    rx_if.channel_index <= w.ch_idx;
    do @(posedge clk_i); while (!rx_if.ready);
    words_counted++;
    if (typed) exp_chan_q.push_back(typed_res);
    else predict_word(w);
  endtask

  // Stream frame_tx out, optionally slipping channel reads in between the bytes.
  task automatic send_frame(input bit with_reads);
    for (int i = 0; i < FrameDepth; i++) begin
      if (with_reads && $urandom_range(0, 7) == 0) send_word(read_word(ChNumW'($urandom)));
      send_word(byte_word(frame_tx[i]));
    end
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (exp_chan_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random back-pressure, with quiet stretches where ready stays high.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (cycle_cnt[9:8] == 2'd0 || $urandom_range(0, 99) < 75) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= 1'b0;
      stall_left   <= pick_len() - 1;
    end
  end

  // Compare each accepted result word with the oldest expectation, field by field.
  always @(posedge clk_i) begin : chk_results
    chan_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (exp_chan_q.size() == 0) begin
        $error("unexpected result: kind %0d channel %0d value 0x%03h last %0d",
               res_if.kind, res_if.channel_number, res_if.channel_value, res_if.last);
        err_cnt++;
      end else begin
        want = exp_chan_q.pop_front();
        if (res_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
          err_cnt++;
        end
        if (res_if.channel_number !== want.ch_num) begin
          $error("channel_number: expected %0d, got %0d", want.ch_num, res_if.channel_number);
          err_cnt++;
        end
        if (res_if.channel_value !== want.ch_val) begin
          $error("channel_value: expected 0x%03h, got 0x%03h", want.ch_val,
                 res_if.channel_value);
          err_cnt++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_if.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: stop a hung run well past the slowest legal one.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    int        r;
    int        n;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    rx_if.valid         = 1'b0;
    rx_if.operation     = OpByte;
    rx_if.rx_byte       = '0;
    rx_if.channel_index = '0;
    res_if.ready        = 1'b0;
    err_cnt             = 0;
    cycle_cnt           = 0;
    words_counted       = 0;
    stall_left          = 0;
    pred_pos            = PosHdr0;
    pred_sum            = '0;
    for (int i = 0; i < FrameDepth; i++) pred_buf[i] = '0;
    for (int i = 0; i < Chans; i++) pred_chan[i] = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: walk the plan table
    for (int k = 0; k < DirRows; k++) begin
      row = DirPlan[k];
      if (row.kind == RowFrame) begin
        fill_frame(row.base, row.stride, 1'b0, row.bad);
        send_frame(1'b0);
      end else begin
        send_word(row.word, row.typed, row.res);
      end
    end
    wait_drained();

    // Random part: mostly well-formed frames with random payload, the rest broken
    // frames, header noise and bursts of reads.
    words_counted = 0;
    while (words_counted < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        fill_frame(8'h00, 8'h00, 1'b1, 1'b0);
        send_frame(1'b1);
      end else if (r < 68) begin
        fill_frame(8'h00, 8'h00, 1'b1, 1'b1);
        send_frame(1'b1);
      end else if (r < 78) begin
        // header noise: stray bytes, with a fair share of first header bytes
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) send_word(byte_word(Hdr0));
          else send_word(byte_word(ByteW'($urandom)));
        end
      end else if (r < 88) begin
        n = $urandom_range(1, 5);
        repeat (n) send_word(read_word(ChNumW'($urandom)));
      end else begin
        // truncated frame: the next words land in its payload until it closes
        send_word(byte_word(Hdr0));
        send_word(byte_word(Hdr1));
        n = $urandom_range(0, 27);
        repeat (n) send_word(byte_word(ByteW'($urandom)));
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // Drain, then give a trailing frame end time to show anything spurious
    wait_drained();
    repeat (4 * Chans) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
